/* rtl/adpc_pkg.sv */
`default_nettype none

package adpc_pkg;

   // configuration register indexes
   localparam logic [2:0] CSR_PIXEL_MODE      = 3'd0;
   localparam logic [2:0] CSR_BYTES_PER_PIXEL = 3'd1;
   localparam logic [2:0] CSR_RED_SHIFT       = 3'd2;
   localparam logic [2:0] CSR_GREEN_SHIFT     = 3'd3;
   localparam logic [2:0] CSR_BLUE_SHIFT      = 3'd4;
   localparam logic [2:0] CSR_RED_BITS        = 3'd5;
   localparam logic [2:0] CSR_GREEN_BITS      = 3'd6;
   localparam logic [2:0] CSR_BLUE_BITS       = 3'd7;

   // pixel modes, also used as the request kind in the queue
   localparam logic [1:0] MODE_DIRECT       = 2'd0;
   localparam logic [1:0] MODE_DIRECT_ALPHA = 2'd1;
   localparam logic [1:0] MODE_PALETTE      = 2'd2;
   localparam logic [1:0] MODE_MONO         = 2'd3;

   localparam logic CMD_CONVERT     = 1'b0;
   localparam logic CMD_TABLE_WRITE = 1'b1;

   localparam logic [2:0] BPP_ONE  = 3'd1;
   localparam logic [2:0] BPP_TWO  = 3'd2;
   localparam logic [2:0] BPP_FOUR = 3'd4;

   localparam int QUEUE_DEPTH = 4;
   localparam int OUT_DEPTH   = 4;

   typedef struct packed {
      logic [1:0] pixel_mode;
      logic [2:0] bytes_per_pixel;
      logic [4:0] red_shift;
      logic [4:0] green_shift;
      logic [4:0] blue_shift;
      logic [4:0] red_bits;
      logic [4:0] green_bits;
      logic [4:0] blue_bits;
   } adpc_cfg_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] argb;
      logic        row_end;
      logic [7:0]  table_byte;
   } adpc_item_type;

endpackage

`default_nettype wire

/* rtl/adpc_front.sv */
`default_nettype none

module adpc_front import adpc_pkg::*; #(
   parameter int TABLE_INDEX_BITS = 15
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  adpc_cfg_type       cfg,
   input  wire logic          push,
   output logic               full,
   input  wire logic          command,
   input  wire logic [31:0]   argb,
   input  wire logic          row_end,
   input  wire logic [14:0]   table_index,
   input  wire logic [7:0]    table_value,
   input  wire logic          q_full,
   output logic               q_push,
   output adpc_item_type      q_item
);

   localparam int AddrBits = TABLE_INDEX_BITS;
   localparam int Depth    = 1 << TABLE_INDEX_BITS;

   logic [7:0] table_mem [Depth];

   logic [AddrBits+14:0] widx_wide;
   logic [AddrBits+14:0] ridx_wide;
   logic [AddrBits-1:0]  waddr;
   logic [AddrBits-1:0]  raddr;

   logic        accept;
   logic        can_move;
   logic        keep;
   logic        st_valid_ff;
   logic        st_valid_in;
   logic [1:0]  st_kind_ff;
   logic [31:0] st_argb_ff;
   logic        st_row_ff;
   logic [7:0]  rdata_ff;

   assign widx_wide = {{AddrBits{1'b0}}, table_index};
   assign ridx_wide = {{AddrBits{1'b0}}, argb[23:19], argb[15:11], argb[7:3]};
   assign waddr     = widx_wide[AddrBits-1:0];
   assign raddr     = ridx_wide[AddrBits-1:0];

   assign q_push   = st_valid_ff && !q_full;
   assign can_move = !st_valid_ff || !q_full;
   assign full     = !can_move;
   assign accept   = push && can_move;

   // table writes, and direct mode with an unsupported byte count, give nothing
   always_comb begin
      keep = 1'b0;
      if (command == CMD_CONVERT) begin
         unique case (cfg.pixel_mode)
            MODE_DIRECT, MODE_DIRECT_ALPHA: begin
               keep = (cfg.bytes_per_pixel == BPP_ONE) || (cfg.bytes_per_pixel == BPP_TWO) ||
                      (cfg.bytes_per_pixel == BPP_FOUR);
            end
            default: begin
               keep = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      st_valid_in = st_valid_ff;
      if (accept && keep) begin
         st_valid_in = 1'b1;
      end else if (q_push) begin
         st_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= st_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         st_kind_ff <= cfg.pixel_mode;
         st_argb_ff <= argb;
         st_row_ff  <= row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (command == CMD_TABLE_WRITE)) begin
         table_mem[waddr] <= table_value;
      end
      if (accept && (command == CMD_CONVERT)) begin
         rdata_ff <= table_mem[raddr];
      end
   end

   assign q_item.kind       = st_kind_ff;
   assign q_item.argb       = st_argb_ff;
   assign q_item.row_end    = st_row_ff;
   assign q_item.table_byte = rdata_ff;

endmodule

`default_nettype wire

/* rtl/adpc_queue.sv */
`default_nettype none

module adpc_queue import adpc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     wr_en,
   input  adpc_item_type wr_item,
   output logic          q_full,
   input  wire logic     rd_en,
   output adpc_item_type rd_item,
   output logic          q_empty
);

   localparam int PtrBits = $clog2(QUEUE_DEPTH);
   localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

   adpc_item_type slot_ff [QUEUE_DEPTH];

   logic [PtrBits-1:0] wr_ptr_ff;
   logic [PtrBits-1:0] wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff;
   logic [PtrBits-1:0] rd_ptr_in;
   logic [CntBits-1:0] count_ff;
   logic [CntBits-1:0] count_in;
   logic               do_wr;
   logic               do_rd;

   assign q_full  = (count_ff == CntBits'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_wr   = wr_en && !q_full;
   assign do_rd   = rd_en && !q_empty;
   assign rd_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

/* rtl/adpc_back.sv */
`default_nettype none

module adpc_back import adpc_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  adpc_cfg_type      cfg,
   input  wire logic         q_empty,
   input  adpc_item_type     q_item,
   output logic              q_pop,
   output logic              empty,
   input  wire logic         pop,
   output logic [31:0]       pixel_bytes,
   output logic [2:0]        byte_count,
   output logic              row_last
);

   localparam int PtrBits = $clog2(OUT_DEPTH);
   localparam int CntBits = $clog2(OUT_DEPTH + 1);

   // whole part of v*(2^b-1)/255: 2^b = 255*q + 2^(b mod 8), q = sum of 2^(b-8j)
   function automatic logic [31:0] scale_whole(input logic [7:0] v, input logic [4:0] b);
      logic [31:0] v32;
      logic [31:0] acc;
      v32 = {24'd0, v};
      acc = '0;
      if (b >= 5'd8) begin
         acc = acc + (v32 << (b - 5'd8));
      end
      if (b >= 5'd16) begin
         acc = acc + (v32 << (b - 5'd16));
      end
      if (b >= 5'd24) begin
         acc = acc + (v32 << (b - 5'd24));
      end
      return acc;
   endfunction

   // remainder part: (v*(2^(b mod 8)-1)+127)/255, operand stays below 2^15
   function automatic logic [7:0] scale_frac(input logic [7:0] v, input logic [4:0] b);
      logic [15:0] y;
      logic [15:0] q;
      y = (16'({8'd0, v}) << b[2:0]) - 16'({8'd0, v}) + 16'd127;
      q = (y + (y >> 8) + 16'd1) >> 8;
      return q[7:0];
   endfunction

   logic [7:0]  ch_val  [3];
   logic [4:0]  ch_bits [3];
   logic [4:0]  ch_shift[3];

   logic        issue;
   logic        credit_ok;

   logic [7:0]  mono_acc_ff;
   logic [7:0]  mono_acc_in;
   logic [2:0]  mono_pos_ff;
   logic [2:0]  mono_pos_in;
   logic        mono_emit;
   logic [7:0]  mono_byte;

   logic        s1_valid_ff;
   logic        s1_valid_in;
   logic [1:0]  s1_kind_ff;
   logic        s1_row_ff;
   logic [7:0]  s1_byte_ff;
   logic [7:0]  s1_alpha_ff;
   logic [31:0] s1_whole_ff[3];
   logic [7:0]  s1_frac_ff [3];

   logic [31:0] packed_word;
   logic [31:0] res_word;
   logic [2:0]  res_count;

   logic [31:0]        out_word_ff [OUT_DEPTH];
   logic [2:0]         out_count_ff[OUT_DEPTH];
   logic               out_last_ff [OUT_DEPTH];
   logic [PtrBits-1:0] wr_ptr_ff;
   logic [PtrBits-1:0] wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff;
   logic [PtrBits-1:0] rd_ptr_in;
   logic [CntBits-1:0] fill_ff;
   logic [CntBits-1:0] fill_in;
   logic               do_wr;
   logic               do_rd;

   always_comb begin
      ch_val[0]   = q_item.argb[23:16];
      ch_val[1]   = q_item.argb[15:8];
      ch_val[2]   = q_item.argb[7:0];
      ch_bits[0]  = cfg.red_bits;
      ch_bits[1]  = cfg.green_bits;
      ch_bits[2]  = cfg.blue_bits;
      ch_shift[0] = cfg.red_shift;
      ch_shift[1] = cfg.green_shift;
      ch_shift[2] = cfg.blue_shift;
   end

   // only issue when the result buffer has room for everything in flight
   assign credit_ok = ({1'b0, fill_ff} + {{CntBits{1'b0}}, s1_valid_ff}) <
                      (CntBits + 1)'(OUT_DEPTH);
   assign issue     = !q_empty && credit_ok;
   assign q_pop     = issue;

   always_comb begin
      mono_acc_in = mono_acc_ff;
      mono_pos_in = mono_pos_ff;
      mono_byte   = mono_acc_ff;
      mono_emit   = 1'b0;
      if (issue && (q_item.kind == MODE_MONO)) begin
         mono_byte = mono_acc_ff;
         if (q_item.table_byte != 8'd0) begin
            mono_byte = mono_acc_ff | (8'h80 >> mono_pos_ff);
         end
         mono_emit = (mono_pos_ff == 3'd7) || q_item.row_end;
         if (mono_emit) begin
            mono_acc_in = '0;
            mono_pos_in = '0;
         end else begin
            mono_acc_in = mono_byte;
            mono_pos_in = mono_pos_ff + 1'b1;
         end
      end
   end

   always_comb begin
      s1_valid_in = 1'b0;
      if (issue) begin
         s1_valid_in = (q_item.kind != MODE_MONO) || mono_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mono_acc_ff <= '0;
         mono_pos_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         mono_acc_ff <= mono_acc_in;
         mono_pos_ff <= mono_pos_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         // a flushed monochrome byte travels on as a plain byte result
         s1_kind_ff  <= (q_item.kind == MODE_MONO) ? MODE_PALETTE : q_item.kind;
         s1_row_ff   <= q_item.row_end;
         s1_byte_ff  <= (q_item.kind == MODE_MONO) ? mono_byte : q_item.table_byte;
         s1_alpha_ff <= q_item.argb[31:24];
         for (int i = 0; i < 3; i++) begin
            s1_whole_ff[i] <= scale_whole(ch_val[i], ch_bits[i]);
            s1_frac_ff[i]  <= scale_frac(ch_val[i], ch_bits[i]);
         end
      end
   end

   always_comb begin
      packed_word = '0;
      for (int i = 0; i < 3; i++) begin
         packed_word = packed_word |
                       ((s1_whole_ff[i] + {24'd0, s1_frac_ff[i]}) << ch_shift[i]);
      end
      if (s1_kind_ff == MODE_DIRECT_ALPHA) begin
         packed_word = packed_word | {s1_alpha_ff, 24'd0};
      end
      res_word  = {24'd0, s1_byte_ff};
      res_count = BPP_ONE;
      unique case (s1_kind_ff)
         MODE_DIRECT, MODE_DIRECT_ALPHA: begin
            res_count = cfg.bytes_per_pixel;
            case (cfg.bytes_per_pixel)
               BPP_ONE: res_word = {24'd0, packed_word[7:0]};
               BPP_TWO: res_word = {16'd0, packed_word[15:0]};
               default: res_word = packed_word;
            endcase
         end
         default: begin
            res_word  = {24'd0, s1_byte_ff};
            res_count = BPP_ONE;
         end
      endcase
   end

   assign do_wr = s1_valid_ff;
   assign empty = (fill_ff == '0);
   assign do_rd = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         out_word_ff[wr_ptr_ff]  <= res_word;
         out_count_ff[wr_ptr_ff] <= res_count;
         out_last_ff[wr_ptr_ff]  <= s1_row_ff;
      end
   end

   assign pixel_bytes = out_word_ff[rd_ptr_ff];
   assign byte_count  = out_count_ff[rd_ptr_ff];
   assign row_last    = out_last_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* rtl/argb_to_display_pixel_converter.sv */
`default_nettype none

// ARGB8888 to display pixel converter. Requests enter on push/full, one per clock
// while full is low; results leave on empty/pop, oldest first. A request is either
// a pixel to convert or a palette table write (table writes and direct pixels with
// a byte count other than 1, 2 or 4 give no result). Sustained rate, while results
// are popped, is one request per clock, set by the single table port, which takes
// one write or one read each cycle. A result passes the front register with the
// table read, a queue slot, the channel scaling register and a result buffer slot
// on its way to the output ports. In monochrome mode a result comes every eighth
// pixel or at row end. Palette entries must be written before they are looked up.
// The configuration port is always ready; write it only while the block is idle.

module argb_to_display_pixel_converter import adpc_pkg::*; #(
   parameter int TABLE_INDEX_BITS = 15
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_command,
   input  wire logic [31:0] req_argb,
   input  wire logic        req_row_end,
   input  wire logic [14:0] req_table_index,
   input  wire logic [7:0]  req_table_value,
   output logic             empty,
   input  wire logic        pop,
   output logic [31:0]      rsp_pixel_bytes,
   output logic [2:0]       rsp_byte_count,
   output logic             rsp_row_last,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [4:0]  csr_wdata
);

   adpc_cfg_type  cfg_ff;
   adpc_cfg_type  cfg_in;
   adpc_item_type front_item;
   adpc_item_type back_item;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_empty;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PIXEL_MODE:      cfg_in.pixel_mode      = csr_wdata[1:0];
            CSR_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_wdata[2:0];
            CSR_RED_SHIFT:       cfg_in.red_shift       = csr_wdata;
            CSR_GREEN_SHIFT:     cfg_in.green_shift     = csr_wdata;
            CSR_BLUE_SHIFT:      cfg_in.blue_shift      = csr_wdata;
            CSR_RED_BITS:        cfg_in.red_bits        = csr_wdata;
            CSR_GREEN_BITS:      cfg_in.green_bits      = csr_wdata;
            CSR_BLUE_BITS:       cfg_in.blue_bits       = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_mode      <= MODE_DIRECT;
         cfg_ff.bytes_per_pixel <= BPP_FOUR;
         cfg_ff.red_shift       <= 5'd16;
         cfg_ff.green_shift     <= 5'd8;
         cfg_ff.blue_shift      <= 5'd0;
         cfg_ff.red_bits        <= 5'd8;
         cfg_ff.green_bits      <= 5'd8;
         cfg_ff.blue_bits       <= 5'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   adpc_front #(
      .TABLE_INDEX_BITS(TABLE_INDEX_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .push       (push),
      .full       (full),
      .command    (req_command),
      .argb       (req_argb),
      .row_end    (req_row_end),
      .table_index(req_table_index),
      .table_value(req_table_value),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (front_item)
   );

   adpc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (q_push),
      .wr_item(front_item),
      .q_full (q_full),
      .rd_en  (q_pop),
      .rd_item(back_item),
      .q_empty(q_empty)
   );

   adpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_item     (back_item),
      .q_pop      (q_pop),
      .empty      (empty),
      .pop        (pop),
      .pixel_bytes(rsp_pixel_bytes),
      .byte_count (rsp_byte_count),
      .row_last   (rsp_row_last)
   );

endmodule

`default_nettype wire

/* tb/pixel_result_checker.sv */
`timescale 1ns / 1ps

module pixel_result_checker import adpc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire logic        full,
   input  wire logic        req_command,
   input  wire logic [31:0] req_argb,
   input  wire logic        req_row_end,
   input  wire logic [14:0] req_table_index,
   input  wire logic [7:0]  req_table_value,
   input  wire logic        empty,
   input  wire logic        pop,
   input  wire logic [31:0] rsp_pixel_bytes,
   input  wire logic [2:0]  rsp_byte_count,
   input  wire logic        rsp_row_last,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [4:0]  csr_wdata,
   output int unsigned      mismatch_count,
   output int unsigned      results_owed
);

   typedef struct packed {
      logic [31:0] pixel_bytes;
      logic [2:0]  byte_count;
      logic        row_last;
   } pixel_result_type;

   adpc_cfg_type     cfg;
   logic [7:0]       palette_mem [0:32767];
   logic [7:0]       mono_acc;
   logic [2:0]       mono_pos;
   pixel_result_type expected_pixels [$];

   function automatic logic [31:0] scale_channel(input logic [7:0] level,
                                                 input logic [4:0] shift,
                                                 input logic [4:0] bits);
      logic [63:0] full_scale;
      logic [63:0] scaled;
      full_scale = (64'd1 << bits) - 64'd1;
      scaled = ({56'd0, level} * full_scale + 64'd127) / 64'd255;
      scaled = scaled << shift;
      return scaled[31:0];
   endfunction

   // 5-5-5 rgb address from the top bits of each channel
   function automatic logic [7:0] palette_byte(input logic [31:0] argb);
      return palette_mem[{argb[23:19], argb[15:11], argb[7:3]}];
   endfunction

   task automatic predict_conversion(input logic        command,
                                     input logic [31:0] argb,
                                     input logic        row_end,
                                     input logic [14:0] tidx,
                                     input logic [7:0]  tval);
      logic [31:0]      word;
      pixel_result_type res;
      if (command == CMD_TABLE_WRITE) begin
         palette_mem[tidx] = tval;
         return;
      end
      res.row_last   = row_end;
      res.byte_count = 3'd1;
      case (cfg.pixel_mode)
         MODE_DIRECT, MODE_DIRECT_ALPHA: begin
            word = scale_channel(argb[23:16], cfg.red_shift, cfg.red_bits)
                 | scale_channel(argb[15:8], cfg.green_shift, cfg.green_bits)
                 | scale_channel(argb[7:0], cfg.blue_shift, cfg.blue_bits);
            // 8-bit alpha scales to itself
            if (cfg.pixel_mode == MODE_DIRECT_ALPHA)
               word = word | {argb[31:24], 24'd0};
            res.byte_count = cfg.bytes_per_pixel;
            case (cfg.bytes_per_pixel)
               BPP_ONE:  res.pixel_bytes = {24'd0, word[7:0]};
               BPP_TWO:  res.pixel_bytes = {16'd0, word[15:0]};
               BPP_FOUR: res.pixel_bytes = word;
               default:  return;
            endcase
            expected_pixels.push_back(res);
         end
         MODE_PALETTE: begin
            res.pixel_bytes = {24'd0, palette_byte(argb)};
            expected_pixels.push_back(res);
         end
         default: begin
            if (palette_byte(argb) != 8'd0)
               mono_acc = mono_acc | (8'h80 >> mono_pos);
            if (mono_pos == 3'd7 || row_end) begin
               res.pixel_bytes = {24'd0, mono_acc};
               expected_pixels.push_back(res);
               mono_acc = 8'd0;
               mono_pos = 3'd0;
            end else begin
               mono_pos = mono_pos + 3'd1;
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t: %s expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      pixel_result_type head;
      if (reset) begin
         cfg.pixel_mode      = MODE_DIRECT;
         cfg.bytes_per_pixel = BPP_FOUR;
         cfg.red_shift       = 5'd16;
         cfg.green_shift     = 5'd8;
         cfg.blue_shift      = 5'd0;
         cfg.red_bits        = 5'd8;
         cfg.green_bits      = 5'd8;
         cfg.blue_bits       = 5'd8;
         mono_acc = 8'd0;
         mono_pos = 3'd0;
         mismatch_count = 0;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PIXEL_MODE:      cfg.pixel_mode      = csr_wdata[1:0];
               CSR_BYTES_PER_PIXEL: cfg.bytes_per_pixel = csr_wdata[2:0];
               CSR_RED_SHIFT:       cfg.red_shift       = csr_wdata;
               CSR_GREEN_SHIFT:     cfg.green_shift     = csr_wdata;
               CSR_BLUE_SHIFT:      cfg.blue_shift      = csr_wdata;
               CSR_RED_BITS:        cfg.red_bits        = csr_wdata;
               CSR_GREEN_BITS:      cfg.green_bits      = csr_wdata;
               CSR_BLUE_BITS:       cfg.blue_bits       = csr_wdata;
               default: ;
            endcase
         end
         if (push && !full)
            predict_conversion(req_command, req_argb, req_row_end,
                               req_table_index, req_table_value);
         if (pop && !empty) begin
            if (expected_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result %h with nothing expected", $realtime,
                           rsp_pixel_bytes);
            end else begin
               head = expected_pixels.pop_front();
               check_field("pixel_bytes", head.pixel_bytes, rsp_pixel_bytes);
               check_field("byte_count", {29'd0, head.byte_count},
                           {29'd0, rsp_byte_count});
               check_field("row_last", {31'd0, head.row_last}, {31'd0, rsp_row_last});
            end
         end
      end
      results_owed = expected_pixels.size();
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb import adpc_pkg::*; ;

   localparam int unsigned RUN_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_command = CMD_CONVERT;
   logic [31:0] req_argb = 32'd0;
   logic        req_row_end = 1'b0;
   logic [14:0] req_table_index = 15'd0;
   logic [7:0]  req_table_value = 8'd0;
   logic        empty;
   logic        pop = 1'b0;
   logic [31:0] rsp_pixel_bytes;
   logic [2:0]  rsp_byte_count;
   logic        rsp_row_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_PIXEL_MODE;
   logic [4:0]  csr_wdata = 5'd0;

   int unsigned mismatch_count;
   int unsigned results_owed;
   int unsigned cycle_count = 0;
   int          tx_idle_pct = 0;
   int          rx_stall_pct = 0;
   logic [1:0]  cur_mode = MODE_DIRECT;
   bit          loaded_map [0:32767];
   logic [14:0] loaded_list [$];

   argb_to_display_pixel_converter DUT (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_command(req_command),
      .req_argb(req_argb),
      .req_row_end(req_row_end),
      .req_table_index(req_table_index),
      .req_table_value(req_table_value),
      .empty(empty),
      .pop(pop),
      .rsp_pixel_bytes(rsp_pixel_bytes),
      .rsp_byte_count(rsp_byte_count),
      .rsp_row_last(rsp_row_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   pixel_result_checker result_check (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_command(req_command),
      .req_argb(req_argb),
      .req_row_end(req_row_end),
      .req_table_index(req_table_index),
      .req_table_value(req_table_value),
      .empty(empty),
      .pop(pop),
      .rsp_pixel_bytes(rsp_pixel_bytes),
      .rsp_byte_count(rsp_byte_count),
      .rsp_row_last(rsp_row_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .mismatch_count(mismatch_count),
      .results_owed(results_owed)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      pop <= ($urandom_range(1, 100) > rx_stall_pct);
   end

   // push stays high after acceptance so back-to-back requests never glitch it
   task automatic send_request(input logic        command,
                               input logic [31:0] argb,
                               input logic        row_end,
                               input logic [14:0] tidx,
                               input logic [7:0]  tval);
      while ($urandom_range(1, 100) <= tx_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push            <= 1'b1;
      req_command     <= command;
      req_argb        <= argb;
      req_row_end     <= row_end;
      req_table_index <= tidx;
      req_table_value <= tval;
      @(posedge clock);
      while (full) @(posedge clock);
      if (command == CMD_TABLE_WRITE && !loaded_map[tidx]) begin
         loaded_map[tidx] = 1'b1;
         loaded_list.push_back(tidx);
      end
   endtask

   task automatic send_pixel(input logic [31:0] argb, input logic row_end);
      logic [31:0] noise;
      noise = $urandom;
      send_request(CMD_CONVERT, argb, row_end, noise[14:0], noise[22:15]);
   endtask

   task automatic send_table_write(input logic [14:0] tidx, input logic [7:0] tval,
                                   input logic row_end);
      send_request(CMD_TABLE_WRITE, $urandom, row_end, tidx, tval);
   endtask

   // pixel whose 5-5-5 address is tidx, with random filler in the ignored bits
   task automatic palette_pixel(input logic [14:0] tidx, input logic row_end);
      logic [31:0] noise;
      noise = $urandom;
      send_pixel({noise[31:24], tidx[14:10], noise[18:16], tidx[9:5], noise[10:8],
                  tidx[4:0], noise[2:0]}, row_end);
   endtask

   // hold off until every expected result is out, then let the pipe drain
   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [4:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic load_config(input logic [1:0] mode, input logic [2:0] bpp,
                              input logic [4:0] rs, input logic [4:0] gs,
                              input logic [4:0] bs, input logic [4:0] rb,
                              input logic [4:0] gb, input logic [4:0] bb);
      write_register(CSR_PIXEL_MODE, {3'd0, mode});
      write_register(CSR_BYTES_PER_PIXEL, {2'd0, bpp});
      write_register(CSR_RED_SHIFT, rs);
      write_register(CSR_GREEN_SHIFT, gs);
      write_register(CSR_BLUE_SHIFT, bs);
      write_register(CSR_RED_BITS, rb);
      write_register(CSR_GREEN_BITS, gb);
      write_register(CSR_BLUE_BITS, bb);
      csr_valid <= 1'b0;
      cur_mode = mode;
   endtask

   function automatic logic [4:0] random_precision();
      if ($urandom_range(0, 4) == 0)
         return 5'($urandom_range(17, 31));
      return 5'($urandom_range(0, 16));
   endfunction

   task automatic run_random_batch(input int count);
      logic [14:0] tidx;
      logic [7:0]  tval;
      logic        row_end;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) == 0)
            settle();
         row_end = ($urandom_range(0, 11) == 0);
         if ($urandom_range(0, 99) < 15) begin
            tidx = 15'($urandom);
            tval = 8'($urandom);
            // plenty of zero entries so monochrome bytes have both bit values
            if ($urandom_range(0, 1) == 0)
               tval = 8'd0;
            send_table_write(tidx, tval, row_end);
         end else if (cur_mode == MODE_PALETTE || cur_mode == MODE_MONO) begin
            palette_pixel(loaded_list[$urandom_range(0, loaded_list.size() - 1)], row_end);
         end else begin
            send_pixel($urandom, row_end);
         end
      end
   endtask

   initial begin
      int          k;
      logic [1:0]  mode;
      logic [2:0]  bpp;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // direct color at the reset format, then 565 with alpha in four and two bytes, then 332 in one byte
      load_config(MODE_DIRECT, BPP_FOUR, 5'd16, 5'd8, 5'd0, 5'd8, 5'd8, 5'd8);
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b1);
      settle();
      load_config(MODE_DIRECT_ALPHA, BPP_FOUR, 5'd11, 5'd5, 5'd0, 5'd5, 5'd6, 5'd5);
      send_pixel(32'h80FF_7F01, 1'b0);
      send_pixel(32'h7F00_0000, 1'b1);
      settle();
      load_config(MODE_DIRECT_ALPHA, BPP_TWO, 5'd11, 5'd5, 5'd0, 5'd5, 5'd6, 5'd5);
      send_pixel(32'hC0FF_80FF, 1'b0);
      settle();
      load_config(MODE_DIRECT, BPP_ONE, 5'd5, 5'd2, 5'd0, 5'd3, 5'd3, 5'd2);
      send_pixel(32'h00FF_FFFF, 1'b1);
      settle();
      // unsupported byte count gives nothing
      load_config(MODE_DIRECT, 3'd3, 5'd16, 5'd8, 5'd0, 5'd8, 5'd8, 5'd8);
      send_pixel(32'h1234_5678, 1'b0);
      settle();
      // oversized precision, field pushed past bit 31, zero-width blue
      load_config(MODE_DIRECT_ALPHA, BPP_FOUR, 5'd31, 5'd20, 5'd0, 5'd31, 5'd16, 5'd0);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h0180_8080, 1'b1);

      send_table_write(15'h0000, 8'h00, 1'b0);
      send_table_write(15'h7FFF, 8'hFF, 1'b0);
      send_table_write(15'h5555, 8'h3C, 1'b0);
      send_table_write(15'h2AAA, 8'h00, 1'b0);
      settle();
      load_config(MODE_PALETTE, BPP_FOUR, 5'd16, 5'd8, 5'd0, 5'd8, 5'd8, 5'd8);
      palette_pixel(15'h7FFF, 1'b0);
      palette_pixel(15'h5555, 1'b1);
      settle();

      // one full monochrome byte, alternating set and clear
      load_config(MODE_MONO, BPP_FOUR, 5'd16, 5'd8, 5'd0, 5'd8, 5'd8, 5'd8);
      for (int i = 0; i < 8; i++)
         palette_pixel((i % 2 == 0) ? 15'h7FFF : 15'h0000, 1'b0);
      // partial row; a table write with row end set must not flush it
      palette_pixel(15'h7FFF, 1'b0);
      palette_pixel(15'h2AAA, 1'b0);
      send_table_write(15'h1234, 8'h01, 1'b1);
      settle();
      // palette pixel in between, monochrome bits carry over
      load_config(MODE_PALETTE, BPP_FOUR, 5'd16, 5'd8, 5'd0, 5'd8, 5'd8, 5'd8);
      palette_pixel(15'h5555, 1'b0);
      settle();
      load_config(MODE_MONO, BPP_FOUR, 5'd16, 5'd8, 5'd0, 5'd8, 5'd8, 5'd8);
      palette_pixel(15'h1234, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 0;
            end
            1: begin
               tx_idle_pct  = 49;
               rx_stall_pct = 0;
            end
            2: begin
               tx_idle_pct  = 0;
               rx_stall_pct = 49;
            end
            default: begin
               tx_idle_pct  = 26;
               rx_stall_pct = 26;
            end
         endcase
         for (int s = 0; s < 4; s++) begin
            settle();
            k = phase * 4 + s;
            if (k == 0) begin
               load_config(MODE_DIRECT, 3'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
            end else if (k == 5) begin
               load_config(MODE_MONO, 3'd7, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31);
            end else if (k == 10) begin
               load_config(MODE_DIRECT, BPP_FOUR, 5'($urandom), 5'($urandom), 5'($urandom),
                           5'd16, 5'd16, 5'd16);
            end else begin
               mode = 2'($urandom_range(0, 3));
               if ($urandom_range(0, 9) < 7) begin
                  case ($urandom_range(0, 2))
                     0:       bpp = BPP_ONE;
                     1:       bpp = BPP_TWO;
                     default: bpp = BPP_FOUR;
                  endcase
               end else begin
                  bpp = 3'($urandom_range(0, 7));
               end
               load_config(mode, bpp, 5'($urandom), 5'($urandom), 5'($urandom),
                           random_precision(), random_precision(), random_precision());
            end
            run_random_batch(60);
         end
      end

      settle();
      if (mismatch_count == 0 && results_owed == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
